### design/mlfq_pkg.sv
// Shared constants, codes and types for the feedback-queue process scheduler.
// No dependencies; imported by mlfq_sat_unit and mlfq_process_scheduler.
package mlfq_pkg;

	localparam int NUM_SLOTS    = 64;
	localparam int SLOT_W       = $clog2(NUM_SLOTS);
	localparam int NUM_LEVELS   = 4;
	localparam int LVL_W        = 2;
	localparam int COUNTER_BITS = 16;
	localparam int CNT_W        = COUNTER_BITS;
	localparam int BOOST_W      = 8;
	localparam int LIM_W        = CNT_W + BOOST_W;
	localparam int CADDR_W      = SLOT_W + LVL_W;
	localparam int ID_W         = 32;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [LVL_W-1:0] LVL_TOP = 2'd3;

	// slot status codes
	localparam logic [2:0] ST_UNUSED   = 3'd0;
	localparam logic [2:0] ST_EMBRYO   = 3'd1;
	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING  = 3'd4;
	localparam logic [2:0] ST_ZOMBIE   = 3'd5;

	// item kinds
	localparam logic [1:0] K_ALLOC  = 2'd0;
	localparam logic [1:0] K_SELECT = 2'd1;
	localparam logic [1:0] K_FINISH = 2'd2;
	localparam logic [1:0] K_SETST  = 2'd3;

	// requested states on set-state
	localparam logic [1:0] NS_UNUSED   = 2'd0;
	localparam logic [1:0] NS_SLEEPING = 2'd1;
	localparam logic [1:0] NS_RUNNABLE = 2'd2;
	localparam logic [1:0] NS_ZOMBIE   = 2'd3;

	// result status
	localparam logic [1:0] RS_OK      = 2'd0;
	localparam logic [1:0] RS_NONE    = 2'd1;
	localparam logic [1:0] RS_INVALID = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] R_POLICY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] R_SLICE3 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] R_SLICE2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] R_SLICE1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] R_BOOST  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] R_BOTTOM = 3'd5;

	typedef struct packed {
		logic [CNT_W-1:0] a;
		logic [CNT_W-1:0] b;
		logic [LIM_W-1:0] lim;
	} sat_op_t;

	typedef struct packed {
		logic [CNT_W-1:0] sum;
		logic             ge;
	} sat_res_t;

endpackage

### design/mlfq_sat_unit.sv
// Shared saturating counter adder with threshold compare.
// Depends on mlfq_pkg.
module mlfq_sat_unit (
	input  mlfq_pkg::sat_op_t  op,
	output mlfq_pkg::sat_res_t res
);
	import mlfq_pkg::*;

	logic [CNT_W:0]   raw;
	logic [CNT_W-1:0] sat;

	assign raw     = {1'b0, op.a} + {1'b0, op.b};
	assign sat     = raw[CNT_W] ? CNT_MAX : raw[CNT_W-1:0];
	assign res.sum = sat;
	assign res.ge  = {{(LIM_W-CNT_W){1'b0}}, sat} >= op.lim;

endmodule

### design/mlfq_process_scheduler.sv
// Feedback-queue process scheduler: slot tables in local memories, one
// sequencer stepping a shared saturating adder. Depends on mlfq_pkg, mlfq_sat_unit.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in       | in_valid / in_ready     | kind, slot, ticks_used, new_state
//  out      | out_valid / out_ready   | chosen_slot, found, process_id, level, status
//  cfg      | cfg_we                  | cfg_idx, cfg_data
//
// Allocate and select scan the slot table, a read and a check state per slot;
// allocate then clears the new slot's counters for each level. Finish walks
// every slot with read, check and, for a used slot, update states. The memories
// have one read port each with registered data, which sets the per-slot cost.
// A finished transaction waits in the output register while the next is taken.
// Reset clears control state and slot valid bits; no clearing pass is needed.
module mlfq_process_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic [5:0]                          slot,
	input  logic [15:0]                         ticks_used,
	input  logic [1:0]                          new_state,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [5:0]                          chosen_slot,
	output logic                                found,
	output logic [31:0]                         process_id,
	output logic [1:0]                          level,
	output logic [1:0]                          status,
	input  logic                                cfg_we,
	input  logic [mlfq_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [mlfq_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mlfq_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SCAN_RD = 4'd1;
	localparam logic [3:0] S_SCAN_CK = 4'd2;
	localparam logic [3:0] S_CLR     = 4'd3;
	localparam logic [3:0] S_F_RD    = 4'd4;
	localparam logic [3:0] S_F_CHK   = 4'd5;
	localparam logic [3:0] S_F_RUN   = 4'd6;
	localparam logic [3:0] S_L_RD    = 4'd7;
	localparam logic [3:0] S_L_CHK   = 4'd8;
	localparam logic [3:0] S_L_EX    = 4'd9;
	localparam logic [3:0] S_LVL_RD  = 4'd10;
	localparam logic [3:0] S_LVL_CK  = 4'd11;
	localparam logic [3:0] S_DONE    = 4'd12;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

	// configuration
	logic                 policy_q;
	logic [CNT_W-1:0]     slice3_q, slice2_q, slice1_q, bottom_q;
	logic [BOOST_W-1:0]   boost_q;

	// tables
	logic [2:0]       st_mem [NUM_SLOTS];
	logic [LVL_W-1:0] lv_mem [NUM_SLOTS];
	logic [CNT_W-1:0] run_mem [NUM_SLOTS*NUM_LEVELS];
	logic [CNT_W-1:0] wt_mem [NUM_SLOTS*NUM_LEVELS];
	logic [NUM_SLOTS-1:0] vld_q;

	logic [2:0]       st_rd_q;
	logic             vld_rd_q;
	logic [LVL_W-1:0] lv_rd_q;
	logic [CNT_W-1:0] run_rd_q, wt_rd_q;

	// sequencer
	logic [3:0]        state_q;
	logic [1:0]        kind_q, nst_q;
	logic [SLOT_W-1:0] slot_q, idx_q, cnt_q, best_q, rr_q;
	logic [CNT_W-1:0]  ticks_q;
	logic [LVL_W-1:0]  best_lvl_q, cur_lvl_q;
	logic [2:0]        stat_q;
	logic              hit_q;
	logic [LIM_W-1:0]  lim1_q, lim2_q;
	logic [ID_W-1:0]   next_id_q;

	// pending result
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_found_q;
	logic [ID_W-1:0]   res_pid_q;
	logic [LVL_W-1:0]  res_lvl_q;
	logic [1:0]        res_status_q;

	// memory controls
	logic [SLOT_W-1:0]  st_addr, st_wa, lv_wa;
	logic               st_we, lv_we, run_we, wt_we;
	logic [2:0]         st_wd;
	logic [LVL_W-1:0]   lv_wd;
	logic [CADDR_W-1:0] ca, run_wa, wt_wa;
	logic [CNT_W-1:0]   run_wd, wt_wd;

	logic [2:0]        st_eff;
	logic              last, mlfq_take, sel_hit, promote, inc;
	logic [SLOT_W-1:0] idx_nx, sel_best;
	logic [LVL_W-1:0]  sel_lvl;
	logic [CNT_W-1:0]  slice_cur;
	logic [LIM_W-1:0]  wlim;
	logic [2:0]        set_st;
	sat_op_t           op;
	sat_res_t          res;

	mlfq_sat_unit u_sat (.op(op), .res(res));

	assign in_ready = (state_q == S_IDLE);
	assign st_eff   = vld_rd_q ? st_rd_q : ST_UNUSED;
	assign last     = (cnt_q == LAST_SLOT);
	assign idx_nx   = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	assign mlfq_take = (st_eff == ST_RUNNABLE) && (!hit_q || lv_rd_q > best_lvl_q);
	assign sel_hit   = hit_q || mlfq_take;
	assign sel_best  = mlfq_take ? idx_q : best_q;
	assign sel_lvl   = mlfq_take ? lv_rd_q : best_lvl_q;
	assign inc       = (idx_q != slot_q) && (stat_q == ST_RUNNABLE);
	assign promote   = (cur_lvl_q != LVL_TOP) && res.ge;

	always_comb begin
		case (best_lvl_q)
			2'd3:    slice_cur = slice3_q;
			2'd2:    slice_cur = slice2_q;
			2'd1:    slice_cur = slice1_q;
			default: slice_cur = '0;
		endcase
		case (cur_lvl_q)
			2'd0:    wlim = {{(LIM_W-CNT_W){1'b0}}, bottom_q};
			2'd1:    wlim = lim1_q;
			2'd2:    wlim = lim2_q;
			default: wlim = '0;
		endcase
		case (nst_q)
			NS_UNUSED:   set_st = ST_UNUSED;
			NS_SLEEPING: set_st = ST_SLEEPING;
			NS_RUNNABLE: set_st = ST_RUNNABLE;
			default:     set_st = ST_ZOMBIE;
		endcase
	end

	// memory addressing and writes
	always_comb begin
		st_addr = idx_q;
		ca      = {idx_q, lv_rd_q};
		st_we   = 1'b0;  st_wa = idx_q;  st_wd = ST_UNUSED;
		lv_we   = 1'b0;  lv_wa = idx_q;  lv_wd = lv_rd_q;
		run_we  = 1'b0;  run_wa = {best_q, cnt_q[1:0]};  run_wd = '0;
		wt_we   = 1'b0;  wt_wa = {idx_q, cur_lvl_q};     wt_wd = res.sum;
		op.a    = wt_rd_q;
		op.b    = {{(CNT_W-1){1'b0}}, inc};
		op.lim  = wlim;
		unique case (state_q)
			S_SCAN_CK: begin
				if (kind_q == K_ALLOC) begin
					if (st_eff == ST_UNUSED) begin
						st_we = 1'b1;  st_wd = ST_EMBRYO;
						lv_we = 1'b1;  lv_wd = LVL_TOP;
					end
				end else if (!policy_q) begin
					if (st_eff == ST_RUNNABLE) begin
						st_we = 1'b1;  st_wd = ST_RUNNING;
					end
				end else if (last && sel_hit) begin
					st_we = 1'b1;  st_wa = sel_best;  st_wd = ST_RUNNING;
				end
			end
			S_CLR: begin
				run_we = 1'b1;
				wt_we  = 1'b1;
				wt_wa  = {best_q, cnt_q[1:0]};
				wt_wd  = '0;
			end
			S_F_RD, S_LVL_RD: st_addr = slot_q;
			S_F_CHK: begin
				ca = {slot_q, lv_rd_q};
				if (kind_q == K_SETST && st_eff != ST_UNUSED) begin
					st_we = 1'b1;  st_wa = slot_q;  st_wd = set_st;
				end
			end
			S_F_RUN: begin
				op.a   = run_rd_q;
				op.b   = ticks_q;
				op.lim = {{(LIM_W-CNT_W){1'b0}}, slice_cur};
				run_we = 1'b1;
				run_wa = {slot_q, best_lvl_q};
				if (best_lvl_q != '0 && res.ge) begin
					run_wd = '0;
					lv_we  = 1'b1;  lv_wa = slot_q;  lv_wd = best_lvl_q - 1'b1;
				end else begin
					run_wd = res.sum;
				end
				if (stat_q == ST_RUNNING) begin
					st_we = 1'b1;  st_wa = slot_q;  st_wd = ST_RUNNABLE;
				end
			end
			S_L_EX: begin
				wt_we = 1'b1;
				if (promote) begin
					wt_wd = '0;
					lv_we = 1'b1;  lv_wd = cur_lvl_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[st_wa] <= st_wd;
		if (lv_we) lv_mem[lv_wa] <= lv_wd;
		if (run_we) run_mem[run_wa] <= run_wd;
		if (wt_we) wt_mem[wt_wa] <= wt_wd;
		st_rd_q  <= st_mem[st_addr];
		lv_rd_q  <= lv_mem[st_addr];
		run_rd_q <= run_mem[ca];
		wt_rd_q  <= wt_mem[ca];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (st_we) vld_q[st_wa] <= 1'b1;
			vld_rd_q <= vld_q[st_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			slice3_q <= 16'd8;
			slice2_q <= 16'd16;
			slice1_q <= 16'd32;
			boost_q  <= 8'd10;
			bottom_q <= 16'd500;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				R_POLICY: policy_q <= cfg_data[0];
				R_SLICE3: slice3_q <= cfg_data;
				R_SLICE2: slice2_q <= cfg_data;
				R_SLICE1: slice1_q <= cfg_data;
				R_BOOST:  boost_q  <= cfg_data[BOOST_W-1:0];
				R_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// wait limits, fixed for the length of one transaction
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			lim1_q <= boost_q * slice1_q;
			lim2_q <= boost_q * slice2_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			next_id_q <= 32'd1;
			rr_q      <= '0;
			hit_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						kind_q  <= kind;
						slot_q  <= slot;
						ticks_q <= ticks_used;
						nst_q   <= new_state;
						hit_q   <= 1'b0;
						cnt_q   <= '0;
						idx_q   <= (kind == K_SELECT && !policy_q) ? rr_q : '0;
						res_slot_q   <= slot;
						res_found_q  <= 1'b0;
						res_pid_q    <= '0;
						res_lvl_q    <= '0;
						res_status_q <= RS_OK;
						state_q <= (kind == K_ALLOC || kind == K_SELECT) ? S_SCAN_RD : S_F_RD;
					end
				end
				S_SCAN_RD: state_q <= S_SCAN_CK;
				S_SCAN_CK: begin
					if (kind_q == K_ALLOC && st_eff == ST_UNUSED) begin
						best_q  <= idx_q;
						cnt_q   <= '0;
						state_q <= S_CLR;
					end else if (kind_q == K_SELECT && !policy_q && st_eff == ST_RUNNABLE) begin
						rr_q        <= idx_nx;
						res_slot_q  <= idx_q;
						res_found_q <= 1'b1;
						res_lvl_q   <= lv_rd_q;
						state_q     <= S_DONE;
					end else if (last) begin
						if (kind_q == K_SELECT && policy_q && sel_hit) begin
							res_slot_q  <= sel_best;
							res_found_q <= 1'b1;
							res_lvl_q   <= sel_lvl;
						end else begin
							res_slot_q   <= '0;
							res_status_q <= RS_NONE;
						end
						state_q <= S_DONE;
					end else begin
						hit_q      <= sel_hit;
						best_q     <= sel_best;
						best_lvl_q <= sel_lvl;
						idx_q      <= idx_nx;
						cnt_q      <= cnt_q + 1'b1;
						state_q    <= S_SCAN_RD;
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'(NUM_LEVELS - 1)) begin
						res_slot_q  <= best_q;
						res_found_q <= 1'b1;
						res_pid_q   <= next_id_q;
						res_lvl_q   <= LVL_TOP;
						next_id_q   <= next_id_q + 1'b1;
						state_q     <= S_DONE;
					end
				end
				S_F_RD: state_q <= S_F_CHK;
				S_F_CHK: begin
					stat_q     <= st_eff;
					best_lvl_q <= lv_rd_q;
					if (kind_q == K_SETST) begin
						if (st_eff == ST_UNUSED) begin
							if (nst_q != NS_UNUSED) res_status_q <= RS_INVALID;
						end else begin
							res_lvl_q <= lv_rd_q;
						end
						state_q <= S_DONE;
					end else if (st_eff == ST_UNUSED) begin
						res_status_q <= RS_INVALID;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_F_RUN;
					end
				end
				S_F_RUN: begin
					idx_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_L_RD;
				end
				S_L_RD: state_q <= S_L_CHK;
				S_L_CHK: begin
					stat_q    <= st_eff;
					cur_lvl_q <= lv_rd_q;
					if (st_eff != ST_UNUSED) begin
						state_q <= S_L_EX;
					end else if (last) begin
						state_q <= S_LVL_RD;
					end else begin
						idx_q   <= idx_nx;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_L_RD;
					end
				end
				S_L_EX: begin
					if (last) begin
						state_q <= S_LVL_RD;
					end else begin
						idx_q   <= idx_nx;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_L_RD;
					end
				end
				S_LVL_RD: state_q <= S_LVL_CK;
				S_LVL_CK: begin
					res_lvl_q <= lv_rd_q;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid || out_ready)) begin
			chosen_slot <= res_slot_q;
			found       <= res_found_q;
			process_id  <= res_pid_q;
			level       <= res_lvl_q;
			status      <= res_status_q;
		end
	end

endmodule
